// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Delayed implication, held off while reset is asserted.
`define ASSERT_LATER2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("assertion failed: two-cycle implication");

`endif

// File: hw/rtl/biquad_pkg.sv
package biquad_pkg;

    localparam int COEF_W    = 18;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 3;

    typedef logic signed [COEF_W-1:0] t_coef;

    // 1.0 in Q3.14
    localparam t_coef B0_RESET = 18'sd16384;

    typedef enum logic [IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } t_reg_idx;

    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
    } t_coefs;

endpackage

// File: hw/rtl/biquad_regs.sv
module biquad_regs
    import biquad_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_coefs            o_coefs
);

    t_coefs             r_coefs;
    t_coefs             n_coefs;
    logic               wr_en;
    logic [IDX_W-1:0]   idx;
    t_coef              wr_val;
    t_coef              rd_val;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_val = pwdata[COEF_W-1:0];

    always_comb begin
        n_coefs = r_coefs;
        if (wr_en) begin
            case (idx)
                REG_B0:  n_coefs.b0 = wr_val;
                REG_B1:  n_coefs.b1 = wr_val;
                REG_B2:  n_coefs.b2 = wr_val;
                REG_A1:  n_coefs.a1 = wr_val;
                REG_A2:  n_coefs.a2 = wr_val;
                default: n_coefs = r_coefs;    // drop writes past the last register
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= B0_RESET;
            r_coefs.b1 <= '0;
            r_coefs.b2 <= '0;
            r_coefs.a1 <= '0;
            r_coefs.a2 <= '0;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    always_comb begin
        case (idx)
            REG_B0:  rd_val = r_coefs.b0;
            REG_B1:  rd_val = r_coefs.b1;
            REG_B2:  rd_val = r_coefs.b2;
            REG_A1:  rd_val = r_coefs.a1;
            REG_A2:  rd_val = r_coefs.a2;
            default: rd_val = '0;
        endcase
    end

    assign prdata  = {{(DATA_W-COEF_W){1'b0}}, rd_val};
    assign o_coefs = r_coefs;

endmodule

// File: hw/rtl/biquad_dp.sv
module biquad_dp
    import biquad_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x1,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x2,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y1,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y2,
    input  t_coefs                         i_coefs,
    output logic signed [SAMPLE_WIDTH-1:0] o_y,
    output logic                           o_clip
);

    localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
    // three guard bits cover the five-term sum and the rounding offset
    localparam int ACC_W  = PROD_W + 3;

    localparam logic signed [ACC_W-1:0] RND_HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] Y_HI =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] Y_LO = ~Y_HI;

    logic signed [PROD_W-1:0] p_b0;
    logic signed [PROD_W-1:0] p_b1;
    logic signed [PROD_W-1:0] p_b2;
    logic signed [PROD_W-1:0] p_a1;
    logic signed [PROD_W-1:0] p_a2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  rnd;

    assign p_b0 = i_x  * i_coefs.b0;
    assign p_b1 = i_x1 * i_coefs.b1;
    assign p_b2 = i_x2 * i_coefs.b2;
    assign p_a1 = i_y1 * i_coefs.a1;
    assign p_a2 = i_y2 * i_coefs.a2;

    assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
               - ACC_W'(p_a1) - ACC_W'(p_a2);

    // round half up, then drop the fraction bits
    assign rnd = (acc + RND_HALF) >>> COEF_FRAC_BITS;

    always_comb begin
        if (rnd > Y_HI) begin
            o_y    = Y_HI[SAMPLE_WIDTH-1:0];
            o_clip = 1'b1;
        end else if (rnd < Y_LO) begin
            o_y    = Y_LO[SAMPLE_WIDTH-1:0];
            o_clip = 1'b1;
        end else begin
            o_y    = rnd[SAMPLE_WIDTH-1:0];
            o_clip = 1'b0;
        end
    end

endmodule

// File: hw/rtl/biquad_iir_filter.sv
// Second-order IIR section, direct form I, one sample per transaction.
// Input channel: i_valid / o_ready with i_sample_in. Output channel:
// o_valid / i_ready with o_sample_out and o_clipped (set when the rounded
// sum hit the sample range limit and was clamped).
// Coefficients b0, b1, b2, a1, a2 sit on an APB-style port at byte
// addresses 0, 4, 8, 12, 16; write them only while the filter is idle.
// A sample taken is held in the input register and moves into the result
// register, which drives the output, once that register is free or
// draining. Throughput: one sample per cycle while the receiver takes
// results; the five multipliers and the adder feeding the result register
// sit in the combinational feedback through the output delay line.
// Reset clears both delay lines, both valid flags and the coefficients
// (b0 = 1.0, the rest 0), so the filter starts as a pass-through.
// When the receiver stalls, the result register holds and one more sample
// is still taken into the input register; after that o_ready drops until
// the output moves.
module biquad_iir_filter
    import biquad_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                    o_clipped,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    t_coefs                         coefs;
    logic                           in_acc;
    logic                           adv;
    logic                           r_in_vld;
    logic                           n_in_vld;
    logic                           r_out_vld;
    logic                           n_out_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SAMPLE_WIDTH-1:0] r_x1;
    logic signed [SAMPLE_WIDTH-1:0] r_x2;
    logic signed [SAMPLE_WIDTH-1:0] r_y1;
    logic signed [SAMPLE_WIDTH-1:0] r_y2;
    logic signed [SAMPLE_WIDTH-1:0] r_y;
    logic                           r_clip;
    logic signed [SAMPLE_WIDTH-1:0] y;
    logic                           clip;

    biquad_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (coefs)
    );

    biquad_dp #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_x     (r_x),
        .i_x1    (r_x1),
        .i_x2    (r_x2),
        .i_y1    (r_y1),
        .i_y2    (r_y2),
        .i_coefs (coefs),
        .o_y     (y),
        .o_clip  (clip)
    );

    // advance the held sample when the result register is free or draining
    assign adv     = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || adv;
    assign in_acc  = i_valid && o_ready;

    always_comb begin
        n_in_vld = r_in_vld;
        if (in_acc) begin
            n_in_vld = 1'b1;
        end else if (adv) begin
            n_in_vld = 1'b0;
        end
        n_out_vld = r_out_vld;
        if (adv) begin
            n_out_vld = 1'b1;
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_x1      <= '0;
            r_x2      <= '0;
            r_y1      <= '0;
            r_y2      <= '0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (adv) begin
                r_x1 <= r_x;
                r_x2 <= r_x1;
                r_y1 <= y;
                r_y2 <= r_y1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= i_sample_in;
        end
        if (adv) begin
            r_y    <= y;
            r_clip <= clip;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_sample_out = r_y;
    assign o_clipped    = r_clip;

endmodule

// File: hw/rtl/biquad_chk.sv
`include "assert_macros.svh"

module biquad_chk
    import biquad_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_ready,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic [SAMPLE_WIDTH-1:0] o_sample_out,
    input logic                    o_clipped,
    input logic                    pready
);

    // nothing comes out straight after reset
    `ASSERT_SAME(a_idle_after_rst, i_clk, i_rst_n, $past(!i_rst_n), !o_valid)

    // a stalled result holds its value
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
                 o_valid && $stable(o_sample_out) && $stable(o_clipped))

    // with the result register empty the input side is always ready for a sample
    `ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !o_valid, o_ready && pready)

    // an accepted sample is followed by a valid output, its own or an earlier one still waiting
    `ASSERT_LATER2(a_latency, i_clk, i_rst_n, i_valid && o_ready, o_valid)

endmodule

bind biquad_iir_filter biquad_chk #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_sample_out (o_sample_out),
    .o_clipped    (o_clipped),
    .pready       (pready)
);

// File: verif/biquad_iir_filter_tb.sv
module biquad_iir_filter_tb;
    import biquad_pkg::*;

    localparam int SMP_W        = 16;
    localparam int FRAC_BITS    = 14;
    localparam int CLK_HALF     = 4;
    localparam int RST_CYCLES   = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 225;
    localparam int MAX_REPORTS  = 20;
    localparam int TIMEOUT      = 2_000_000;
    localparam int N_DIRECTED   = 38;

    // Index past the last coefficient: writes there must be dropped
    localparam logic [IDX_W-1:0] UNMAPPED_IDX = 3'd5;

    typedef enum logic {ROW_SAMPLE, ROW_COEF} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [IDX_W-1:0] idx;
        logic [DATA_W-1:0] data;
        logic [SMP_W-1:0] smp;
        logic             known;
        logic [SMP_W-1:0] y;
        logic             clip;
    } t_row;

    typedef struct packed {
        logic [SMP_W-1:0] y;
        logic             clip;
    } t_filter_out;

    // b0-only rows have outputs that do not depend on the delay lines
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'h0000, 1'b1, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'h7FFF, 1'b1, 16'h7FFF, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'h8000, 1'b1, 16'h8000, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'h0001, 1'b1, 16'h0001, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'h5555, 1'b1, 16'h5555, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'hAAAA, 1'b1, 16'hAAAA, 1'b0},
        // b0 at its maximum, junk above bit 17
        '{ROW_COEF,   REG_B0, 32'h5A41FFFF, 16'h0, 1'b0, 16'h0, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'h7FFF, 1'b1, 16'h7FFF, 1'b1},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'h8000, 1'b1, 16'h8000, 1'b1},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'h0000, 1'b1, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'h0002, 1'b0, 16'h0000, 1'b0},
        // b0 at its minimum
        '{ROW_COEF,   REG_B0, 32'hFFFE0000, 16'h0, 1'b0, 16'h0, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'h8000, 1'b1, 16'h7FFF, 1'b1},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'h7FFF, 1'b1, 16'h8000, 1'b1},
        // smallest step: halfway values round towards plus infinity
        '{ROW_COEF,   REG_B0, 32'h00000001, 16'h0, 1'b0, 16'h0, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'h2000, 1'b1, 16'h0001, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'hE000, 1'b1, 16'h0000, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'hDFFF, 1'b1, 16'hFFFF, 1'b0},
        '{ROW_COEF,   REG_B1, 32'h0001FFFF, 16'h0, 1'b0, 16'h0, 1'b0},
        '{ROW_COEF,   REG_B2, 32'h00020000, 16'h0, 1'b0, 16'h0, 1'b0},
        '{ROW_COEF,   REG_A1, 32'h00020000, 16'h0, 1'b0, 16'h0, 1'b0},
        '{ROW_COEF,   REG_A2, 32'h0001FFFF, 16'h0, 1'b0, 16'h0, 1'b0},
        '{ROW_COEF,   REG_B0, 32'h00004000, 16'h0, 1'b0, 16'h0, 1'b0},
        '{ROW_COEF,   UNMAPPED_IDX, 32'hFFFFFFFF, 16'h0, 1'b0, 16'h0, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'd1000, 1'b0, 16'h0, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'hF830, 1'b0, 16'h0, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'h7FFF, 1'b0, 16'h0, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'h8000, 1'b0, 16'h0, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'h0000, 1'b0, 16'h0, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'd12345, 1'b0, 16'h0, 1'b0},
        // integrator: y = x + previous y
        '{ROW_COEF,   REG_B1, 32'h00000000, 16'h0, 1'b0, 16'h0, 1'b0},
        '{ROW_COEF,   REG_B2, 32'h00000000, 16'h0, 1'b0, 16'h0, 1'b0},
        '{ROW_COEF,   REG_A2, 32'h00000000, 16'h0, 1'b0, 16'h0, 1'b0},
        '{ROW_COEF,   REG_A1, 32'hFFFFC000, 16'h0, 1'b0, 16'h0, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'd20000, 1'b0, 16'h0, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'd20000, 1'b0, 16'h0, 1'b0},
        '{ROW_SAMPLE, REG_B0, 32'h0, 16'hFF9C, 1'b0, 16'h0, 1'b0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [SMP_W-1:0]  i_sample_in = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [SMP_W-1:0]  o_sample_out;
    logic              o_clipped;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    t_coefs                  coef_model = '{b0: B0_RESET, default: '0};
    logic signed [SMP_W-1:0] x_hist [2] = '{default: '0};
    logic signed [SMP_W-1:0] y_hist [2] = '{default: '0};
    t_filter_out             expected_out_q [$];
    int                      err_count = 0;
    int                      src_idle_pct = 0;
    int                      snk_idle_pct = 0;

    biquad_iir_filter #(
        .SAMPLE_WIDTH  (SMP_W),
        .COEF_FRAC_BITS(FRAC_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample_in (i_sample_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_sample_out(o_sample_out),
        .o_clipped   (o_clipped),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_filter_out biquad_predict(input logic signed [SMP_W-1:0] x);
        longint      acc;
        longint      rounded;
        longint      hi;
        longint      lo;
        t_filter_out res;
        hi = (longint'(1) <<< (SMP_W - 1)) - 1;
        lo = -hi - 1;
        acc = longint'($signed(coef_model.b0)) * longint'(x)
            + longint'($signed(coef_model.b1)) * longint'(x_hist[0])
            + longint'($signed(coef_model.b2)) * longint'(x_hist[1])
            - longint'($signed(coef_model.a1)) * longint'(y_hist[0])
            - longint'($signed(coef_model.a2)) * longint'(y_hist[1]);
        rounded = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        res.clip = 1'b0;
        if (rounded > hi) begin
            rounded = hi;
            res.clip = 1'b1;
        end else if (rounded < lo) begin
            rounded = lo;
            res.clip = 1'b1;
        end
        res.y = rounded[SMP_W-1:0];
        x_hist[1] = x_hist[0];
        x_hist[0] = x;
        y_hist[1] = y_hist[0];
        y_hist[0] = res.y;
        return res;
    endfunction

    task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'({idx, 2'b00});
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_B0: coef_model.b0 = data[COEF_W-1:0];
            REG_B1: coef_model.b1 = data[COEF_W-1:0];
            REG_B2: coef_model.b2 = data[COEF_W-1:0];
            REG_A1: coef_model.a1 = data[COEF_W-1:0];
            REG_A2: coef_model.a2 = data[COEF_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Hold the sender off until every outstanding sample has come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [SMP_W-1:0] s, input logic use_typed,
                               input t_filter_out typed);
        t_filter_out pred;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_sample_in = s;
        do @(posedge i_clk); while (!o_ready);
        pred = biquad_predict(s);
        expected_out_q.push_back(use_typed ? typed : pred);
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            i_ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_filter_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_out_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected transaction, got %0d clip %0b",
                             $time, $signed(o_sample_out), o_clipped);
            end else begin
                want = expected_out_q.pop_front();
                if (o_sample_out !== want.y || o_clipped !== want.clip) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: mismatch, expected %0d clip %0b, got %0d clip %0b",
                                 $time, $signed(want.y), want.clip,
                                 $signed(o_sample_out), o_clipped);
                end
            end
        end
    end

    initial begin
        #(TIMEOUT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        t_row             row;
        t_filter_out      typed;
        t_filter_out      none;
        t_reg_idx         coef_order [5];
        logic [SMP_W-1:0] s;
        int               style;
        int               cval;
        coef_order = '{REG_B0, REG_B1, REG_B2, REG_A1, REG_A2};
        none = '0;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        src_idle_pct = 21;
        snk_idle_pct = 52;
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED[i];
            if (row.kind == ROW_COEF) begin
                wait_idle();
                write_coef(row.idx, row.data);
            end else begin
                typed.y    = row.y;
                typed.clip = row.clip;
                send_sample(row.smp, row.known, typed);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph / 2)
                0: begin src_idle_pct = 21; snk_idle_pct = 52; end
                1: begin src_idle_pct = 52; snk_idle_pct = 21; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            style = ph % 3;
            wait_idle();
            foreach (coef_order[r]) begin
                case (style)
                    // extremes, unity and zero
                    0: case ($urandom_range(3))
                           0: cval = -131072;
                           1: cval = 131071;
                           2: cval = 0;
                           default: cval = 16384;
                       endcase
                    1: cval = int'($urandom_range(262143)) - 131072;
                    // keep the poles mostly inside the unit circle
                    default: begin
                        if (coef_order[r] == REG_A2)
                            cval = int'($urandom_range(12000));
                        else
                            cval = int'($urandom_range(40000)) - 20000;
                    end
                endcase
                write_coef(coef_order[r],
                           ($urandom & ~32'h3FFFF) | (DATA_W'(cval) & 32'h3FFFF));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    wait_idle();
                case ($urandom_range(9))
                    0: case ($urandom_range(3))
                           0: s = 16'h7FFF;
                           1: s = 16'h8000;
                           2: s = 16'h0000;
                           default: s = 16'hFFFF;
                       endcase
                    1, 2: s = SMP_W'(int'($urandom_range(128)) - 64);
                    default: s = SMP_W'($urandom);
                endcase
                send_sample(s, 1'b0, none);
            end
        end

        wait_idle();
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
